### design/sfpc_pkg.sv
// Shared types and constants for the split-flap position controller.
// Used by every module of the block and by its port checker.
// Depends on nothing.
package sfpc_pkg;

    // Fixed field widths.
    localparam int TIME_BITS  = 32;
    localparam int POS_BITS   = 8;
    localparam int COUNT_BITS = 8;
    localparam int DELAY_BITS = 16;
    localparam int STATE_BITS = 3;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FLAP_COUNT       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPINUP_DELAY     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHUTOFF_DELAY    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLAP_DELAY       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPINUP_CORRECTION = 3'd4;

    // Register values after reset.
    localparam logic [COUNT_BITS-1:0] FLAP_COUNT_RST       = 8'd40;
    localparam logic [DELAY_BITS-1:0] SPINUP_DELAY_RST     = 16'd100;
    localparam logic [DELAY_BITS-1:0] SHUTOFF_DELAY_RST    = 16'd100;
    localparam logic [DELAY_BITS-1:0] FLAP_DELAY_RST       = 16'd100;
    localparam logic [DELAY_BITS-1:0] SPINUP_CORRECTION_RST = 16'd0;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Machine state codes as they appear on the result beat.
    localparam logic [STATE_BITS-1:0] FSM_STOPPED  = 3'd0;
    localparam logic [STATE_BITS-1:0] FSM_SPINUP   = 3'd1;
    localparam logic [STATE_BITS-1:0] FSM_HOMING   = 3'd2;
    localparam logic [STATE_BITS-1:0] FSM_STEPPING = 3'd3;
    localparam logic [STATE_BITS-1:0] FSM_LAST     = 3'd4;
    localparam logic [STATE_BITS-1:0] FSM_SPINDOWN = 3'd5;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Remainder unit: bits of the target handled per cycle.
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = COUNT_BITS / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_BITS       = $clog2(DIV_CYCLES);

    // Input beat.
    typedef struct packed {
        logic                  command;
        logic [COUNT_BITS-1:0] target_value;
        logic [TIME_BITS-1:0]  now_ms;
        logic                  flap_sense;
        logic                  home_sense;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic                  motor_drive;
        logic [POS_BITS-1:0]   position;
        logic [STATE_BITS-1:0] fsm_state;
        logic                  done_res;
    } out_beat_t;

    // Classified operation carried from front to back.
    typedef struct packed {
        logic                 is_set;
        logic [POS_BITS-1:0]  target;
        logic [TIME_BITS-1:0] now_ms;
        logic                 flap_sense;
        logic                 home_sense;
    } op_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

### design/split_flap_position_controller.sv
// Top level of the split-flap position controller: configuration registers,
// front end, operation queue and back end.
// Depends on sfpc_pkg, sfpc_front, sfpc_fifo and sfpc_back.
//
//   Channel | Signals                        | Beat contents
//   input   | in_valid, in_ready, in_data    | command, target, time, sensors
//   result  | out_valid, out_ready, out_data | motor, position, state, done
//   config  | cfg_we, cfg_index, cfg_data    | one register write per cycle
//
// A tick beat is pushed to the queue as it is accepted; the back end moves it
// into the result register when that is empty or taken. A set-target beat goes
// through the remainder unit and waits for queue room; the front stays busy.
// The two-entry queue lets the front keep accepting while the result stalls.
// Reset is asynchronous and active low; the motor is off and position is zero.
module split_flap_position_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sfpc_pkg::in_beat_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sfpc_pkg::out_beat_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [sfpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfpc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [sfpc_pkg::COUNT_BITS-1:0]  flap_count_reg;
    logic [sfpc_pkg::DELAY_BITS-1:0]  spinup_delay_reg;
    logic [sfpc_pkg::DELAY_BITS-1:0]  shutoff_delay_reg;
    logic [sfpc_pkg::DELAY_BITS-1:0]  flap_delay_reg;
    logic [sfpc_pkg::DELAY_BITS-1:0]  spinup_corr_reg;

    logic                     push;
    logic                     pop;
    sfpc_pkg::op_t            push_op;
    sfpc_pkg::op_t            head_op;
    sfpc_pkg::queue_status_t  q_status;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flap_count_reg    <= sfpc_pkg::FLAP_COUNT_RST;
            spinup_delay_reg  <= sfpc_pkg::SPINUP_DELAY_RST;
            shutoff_delay_reg <= sfpc_pkg::SHUTOFF_DELAY_RST;
            flap_delay_reg    <= sfpc_pkg::FLAP_DELAY_RST;
            spinup_corr_reg   <= sfpc_pkg::SPINUP_CORRECTION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfpc_pkg::REG_FLAP_COUNT:
                    flap_count_reg <= cfg_data[sfpc_pkg::COUNT_BITS-1:0];
                sfpc_pkg::REG_SPINUP_DELAY:
                    spinup_delay_reg <= cfg_data;
                sfpc_pkg::REG_SHUTOFF_DELAY:
                    shutoff_delay_reg <= cfg_data;
                sfpc_pkg::REG_FLAP_DELAY:
                    flap_delay_reg <= cfg_data;
                sfpc_pkg::REG_SPINUP_CORRECTION:
                    spinup_corr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sfpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .flap_count (flap_count_reg),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    sfpc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    sfpc_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .head_op              (head_op),
        .q_status             (q_status),
        .pop                  (pop),
        .spinup_delay_ms      (spinup_delay_reg),
        .shutoff_delay_ms     (shutoff_delay_reg),
        .flap_delay_ms        (flap_delay_reg),
        .spinup_correction_ms (spinup_corr_reg),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .out_data             (out_data)
    );

endmodule

### design/sfpc_fifo.sv
// Short operation queue between the front and the back of the controller.
// Depends on sfpc_pkg for the operation type and the depth.
module sfpc_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sfpc_pkg::op_t           push_op,
    input  logic                    pop,
    output sfpc_pkg::op_t           head_op,
    output sfpc_pkg::queue_status_t status
);

    sfpc_pkg::op_t                    entry_reg [sfpc_pkg::QUEUE_DEPTH];
    logic [sfpc_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sfpc_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sfpc_pkg::QPTR_BITS:0]     count_reg, count_next;

    // Pointer and fill count updates; pointers wrap at the power-of-two depth.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op          = entry_reg[rd_ptr_reg];
    assign status.full      = (count_reg == (sfpc_pkg::QPTR_BITS+1)'(sfpc_pkg::QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);

endmodule

### design/sfpc_front.sv
// Front end: accepts input beats, passes ticks on and reduces set-target
// values modulo a nonzero flap count with a two-bits-per-cycle remainder unit.
// Depends on sfpc_pkg.
module sfpc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sfpc_pkg::in_beat_t                   in_data,
    input  logic [sfpc_pkg::COUNT_BITS-1:0]      flap_count,
    input  sfpc_pkg::queue_status_t              q_status,
    output logic                                 push,
    output sfpc_pkg::op_t                        push_op
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t                         state_reg, state_next;
    logic [sfpc_pkg::COUNT_BITS-1:0]      dvd_reg, dvd_next;
    logic [sfpc_pkg::COUNT_BITS-1:0]      rem_reg, rem_next;
    logic [sfpc_pkg::COUNT_BITS-1:0]      orig_reg, orig_next;
    logic [sfpc_pkg::DIV_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [sfpc_pkg::COUNT_BITS-1:0]      rem_step;
    logic [sfpc_pkg::COUNT_BITS-1:0]      dvd_step;
    logic                                 accept;

    assign in_ready = (state_reg == F_IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;

    // Restoring remainder steps, one dividend bit each, most significant first.
    always_comb
    begin
        logic [sfpc_pkg::COUNT_BITS:0] trial;
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        for (int i = 0; i < sfpc_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            trial = {rem_step, dvd_step[sfpc_pkg::COUNT_BITS-1]};
            if (trial >= {1'b0, flap_count})
            begin
                trial = trial - {1'b0, flap_count};
            end
            rem_step = trial[sfpc_pkg::COUNT_BITS-1:0];
            dvd_step = {dvd_step[sfpc_pkg::COUNT_BITS-2:0], 1'b0};
        end
    end

    // Sequencing of the remainder unit and the queue push.
    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        orig_next  = orig_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        push_op    = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                push_op.is_set     = 1'b0;
                push_op.now_ms     = in_data.now_ms;
                push_op.flap_sense = in_data.flap_sense;
                push_op.home_sense = in_data.home_sense;
                if (accept)
                begin
                    if (in_data.command == sfpc_pkg::CMD_SET)
                    begin
                        dvd_next   = in_data.target_value;
                        orig_next  = in_data.target_value;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = F_DIV;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
            end
            F_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sfpc_pkg::DIV_CNT_BITS'(sfpc_pkg::DIV_CYCLES - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                // A flap count of zero means the value is stored as given.
                push_op.is_set = 1'b1;
                push_op.target = (flap_count == '0) ? orig_reg : rem_reg;
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            orig_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            orig_reg  <= orig_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### design/sfpc_back.sv
// Back end: runs the motor state machine on each queued operation and
// holds the result beat in an output register.
// Depends on sfpc_pkg.
module sfpc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sfpc_pkg::op_t                        head_op,
    input  sfpc_pkg::queue_status_t              q_status,
    output logic                                 pop,
    input  logic [sfpc_pkg::DELAY_BITS-1:0]      spinup_delay_ms,
    input  logic [sfpc_pkg::DELAY_BITS-1:0]      shutoff_delay_ms,
    input  logic [sfpc_pkg::DELAY_BITS-1:0]      flap_delay_ms,
    input  logic [sfpc_pkg::DELAY_BITS-1:0]      spinup_correction_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sfpc_pkg::out_beat_t                  out_data
);

    typedef enum logic [sfpc_pkg::STATE_BITS-1:0] {
        S_STOPPED  = sfpc_pkg::FSM_STOPPED,
        S_SPINUP   = sfpc_pkg::FSM_SPINUP,
        S_HOMING   = sfpc_pkg::FSM_HOMING,
        S_STEPPING = sfpc_pkg::FSM_STEPPING,
        S_LAST     = sfpc_pkg::FSM_LAST,
        S_SPINDOWN = sfpc_pkg::FSM_SPINDOWN
    } mode_t;

    mode_t                              mode_reg, mode_next;
    logic [sfpc_pkg::POS_BITS-1:0]      cur_reg, cur_next;
    logic [sfpc_pkg::POS_BITS-1:0]      tgt_reg, tgt_next;
    logic                               level_reg, level_next;
    logic [sfpc_pkg::TIME_BITS-1:0]     deadline_reg, deadline_next;
    logic [sfpc_pkg::DELAY_BITS-1:0]    corr_reg, corr_next;
    logic                               motor_reg, motor_next;
    logic                               out_valid_reg, out_valid_next;
    sfpc_pkg::out_beat_t                out_data_reg, out_data_next;

    logic [sfpc_pkg::TIME_BITS-1:0]     since_deadline;
    logic                               reached;
    logic                               falling;
    logic                               last_hit;
    logic                               done;
    logic [sfpc_pkg::POS_BITS:0]        cur_plus_one;
    logic [sfpc_pkg::TIME_BITS-1:0]     now;
    mode_t                              run_mode;

    assign pop = q_status.not_empty && (!out_valid_reg || out_ready);
    assign now = head_op.now_ms;

    // Wrap-safe deadline test, flap edge detect and last-flap test.
    assign since_deadline = now - deadline_reg;
    assign reached        = !since_deadline[sfpc_pkg::TIME_BITS-1];
    assign falling        = level_reg && !head_op.flap_sense;
    assign cur_plus_one   = {1'b0, cur_reg} + 1'b1;
    assign last_hit       = ({1'b0, tgt_reg} == cur_plus_one);
    assign run_mode       = (tgt_reg < cur_reg) ? S_HOMING : S_STEPPING;

    // One step of the motor machine for the operation at the queue head.
    always_comb
    begin
        mode_next     = mode_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        level_next    = level_reg;
        deadline_next = deadline_reg;
        corr_next     = corr_reg;
        motor_next    = motor_reg;
        done          = 1'b0;
        if (head_op.is_set)
        begin
            tgt_next = head_op.target;
            done     = (mode_reg == S_STOPPED) && (head_op.target == cur_reg);
        end
        else
        begin
            unique case (mode_reg)
                S_STOPPED:
                begin
                    if (tgt_reg == cur_reg)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        level_next    = 1'b0;
                        motor_next    = 1'b1;
                        mode_next     = S_SPINUP;
                        deadline_next = now + sfpc_pkg::TIME_BITS'(spinup_delay_ms);
                    end
                end
                S_SPINUP:
                begin
                    // The sensor is only sampled when the timeout has not hit.
                    if (reached)
                    begin
                        mode_next = run_mode;
                        corr_next = spinup_correction_ms;
                    end
                    else
                    begin
                        level_next = head_op.flap_sense;
                        if (falling)
                        begin
                            mode_next = run_mode;
                            corr_next = '0;
                        end
                    end
                end
                S_HOMING:
                begin
                    if (!head_op.home_sense)
                    begin
                        cur_next      = '0;
                        motor_next    = 1'b0;
                        deadline_next = now + sfpc_pkg::TIME_BITS'(shutoff_delay_ms);
                        mode_next     = S_SPINDOWN;
                    end
                end
                S_STEPPING:
                begin
                    if (last_hit)
                    begin
                        mode_next     = S_LAST;
                        deadline_next = now + sfpc_pkg::TIME_BITS'(flap_delay_ms)
                                        - sfpc_pkg::TIME_BITS'(corr_reg);
                    end
                    else
                    begin
                        level_next = head_op.flap_sense;
                        if (falling)
                        begin
                            cur_next  = cur_plus_one[sfpc_pkg::POS_BITS-1:0];
                            corr_next = '0;
                        end
                    end
                end
                S_LAST:
                begin
                    if (!reached)
                    begin
                        level_next = head_op.flap_sense;
                    end
                    // Timeout or an early flap edge both stop the motor.
                    if (reached || falling)
                    begin
                        motor_next    = 1'b0;
                        cur_next      = tgt_reg;
                        mode_next     = S_SPINDOWN;
                        deadline_next = now + sfpc_pkg::TIME_BITS'(shutoff_delay_ms);
                    end
                end
                S_SPINDOWN:
                begin
                    if (reached)
                    begin
                        mode_next = S_STOPPED;
                    end
                end
                default:
                begin
                    mode_next = S_STOPPED;
                end
            endcase
        end
    end

    // Output register: loaded on a pop, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next            = 1'b1;
            out_data_next.motor_drive = motor_next;
            out_data_next.position    = cur_next;
            out_data_next.fsm_state   = mode_next;
            out_data_next.done_res    = done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= S_STOPPED;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            level_reg     <= 1'b0;
            deadline_reg  <= '0;
            corr_reg      <= '0;
            motor_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg     <= mode_next;
                cur_reg      <= cur_next;
                tgt_reg      <= tgt_next;
                level_reg    <= level_next;
                deadline_reg <= deadline_next;
                corr_reg     <= corr_next;
                motor_reg    <= motor_next;
            end
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/sfpc_checker.sv
// Port checker for the split-flap position controller, bound to the top level.
// Depends on sfpc_pkg and split_flap_position_controller.
module sfpc_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  sfpc_pkg::out_beat_t                  out_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Done is only reported while stopped.
    a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.fsm_state == sfpc_pkg::FSM_STOPPED)
        else $error("done reported outside the stopped state");

    // The motor is released whenever the machine is stopped or spinning down.
    a_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.fsm_state == sfpc_pkg::FSM_STOPPED
                      || out_data.fsm_state == sfpc_pkg::FSM_SPINDOWN)
        |-> !out_data.motor_drive)
        else $error("motor driven while stopped or spinning down");

    // While spinning up the motor must be driven.
    a_motor_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fsm_state == sfpc_pkg::FSM_SPINUP |-> out_data.motor_drive)
        else $error("motor released during spin-up");

endmodule

bind split_flap_position_controller sfpc_checker u_sfpc_checker (.*);

### tb/tb_split_flap_position_controller.sv
// Self-checking testbench for split_flap_position_controller: a directed part, then
// random drum moves under several register setups, checked against a behavioral model.
// Depends on sfpc_pkg and the controller RTL.
module tb_split_flap_position_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 10;
    localparam int MOVE_TICK_CAP = 150;
    localparam int REPORT_LIMIT  = 10;

    // Clock, reset and block inputs, all known from time zero.
    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    sfpc_pkg::in_beat_t                  in_data   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    sfpc_pkg::out_beat_t                 out_data;
    logic                                cfg_we    = 1'b0;
    logic [sfpc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sfpc_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Shadow copy of the configuration registers.
    logic [sfpc_pkg::COUNT_BITS-1:0] flap_total     = sfpc_pkg::FLAP_COUNT_RST;
    logic [sfpc_pkg::DELAY_BITS-1:0] spinup_ms      = sfpc_pkg::SPINUP_DELAY_RST;
    logic [sfpc_pkg::DELAY_BITS-1:0] shutoff_ms     = sfpc_pkg::SHUTOFF_DELAY_RST;
    logic [sfpc_pkg::DELAY_BITS-1:0] flap_ms        = sfpc_pkg::FLAP_DELAY_RST;
    logic [sfpc_pkg::DELAY_BITS-1:0] spinup_trim_ms = sfpc_pkg::SPINUP_CORRECTION_RST;

    // Model of the drum controller state.
    logic [sfpc_pkg::STATE_BITS-1:0] drum_mode   = sfpc_pkg::FSM_STOPPED;
    logic [sfpc_pkg::POS_BITS-1:0]   shown_flap  = '0;
    logic [sfpc_pkg::POS_BITS-1:0]   goal_flap   = '0;
    logic                            prev_flap   = 1'b0;
    logic [sfpc_pkg::TIME_BITS-1:0]  deadline_ms = '0;
    logic [sfpc_pkg::DELAY_BITS-1:0] trim_ms     = '0;
    logic                            motor_on    = 1'b0;

    // Expected result beats and bookkeeping.
    sfpc_pkg::out_beat_t pending_reports[$];
    int        report_errors   = 0;
    int        checked_reports = 0;
    int        items_sent      = 0;
    int        set_beats       = 0;
    int        setups_run      = 0;
    int        phase_end       = 0;
    int        ready_hold      = 0;
    bit        calm_bus        = 1'b0;

    // Simulated drum environment for the random part.
    logic [sfpc_pkg::TIME_BITS-1:0] drum_clock_ms = '0;
    logic                           flap_level    = 1'b0;
    int                             step_max      = 10;

    split_flap_position_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A deadline counts as reached when the wrapped difference is not negative.
    function automatic logic deadline_hit(input logic [sfpc_pkg::TIME_BITS-1:0] now);
        logic [sfpc_pkg::TIME_BITS-1:0] diff;
        diff = now - deadline_ms;
        return !diff[sfpc_pkg::TIME_BITS-1];
    endfunction

    // Falling edge of the flap sensor; the stored level follows every call.
    function automatic logic flap_fell(input logic level);
        logic fell;
        fell = prev_flap && !level;
        prev_flap = level;
        return fell;
    endfunction

    // Motor off on the last flap: position snaps to the goal and spin-down starts.
    function automatic void brake_on_last(input logic [sfpc_pkg::TIME_BITS-1:0] now);
        motor_on = 1'b0;
        shown_flap = goal_flap;
        drum_mode = sfpc_pkg::FSM_SPINDOWN;
        deadline_ms = now + {16'd0, shutoff_ms};
    endfunction

    // Advance the drum model by one beat and form the result it should produce.
    task automatic drum_step(input sfpc_pkg::in_beat_t b, output sfpc_pkg::out_beat_t r);
        logic [sfpc_pkg::STATE_BITS-1:0] next_mode;
        logic                            done;
        done = 1'b0;
        if (b.command == sfpc_pkg::CMD_SET)
        begin
            goal_flap = (flap_total == '0) ? b.target_value : b.target_value % flap_total;
            done = (drum_mode == sfpc_pkg::FSM_STOPPED) && (goal_flap == shown_flap);
        end
        else
        begin
            case (drum_mode)
                sfpc_pkg::FSM_STOPPED:
                begin
                    if (goal_flap == shown_flap)
                        done = 1'b1;
                    else
                    begin
                        prev_flap = 1'b0;
                        motor_on = 1'b1;
                        drum_mode = sfpc_pkg::FSM_SPINUP;
                        deadline_ms = b.now_ms + {16'd0, spinup_ms};
                    end
                end
                sfpc_pkg::FSM_SPINUP:
                begin
                    next_mode = (goal_flap < shown_flap) ? sfpc_pkg::FSM_HOMING
                                                         : sfpc_pkg::FSM_STEPPING;
                    if (deadline_hit(b.now_ms))
                    begin
                        drum_mode = next_mode;
                        trim_ms = spinup_trim_ms;
                    end
                    else if (flap_fell(b.flap_sense))
                    begin
                        drum_mode = next_mode;
                        trim_ms = '0;
                    end
                end
                sfpc_pkg::FSM_HOMING:
                begin
                    if (!b.home_sense)
                    begin
                        shown_flap = '0;
                        motor_on = 1'b0;
                        deadline_ms = b.now_ms + {16'd0, shutoff_ms};
                        drum_mode = sfpc_pkg::FSM_SPINDOWN;
                    end
                end
                sfpc_pkg::FSM_STEPPING:
                begin
                    // The last-flap test does not wrap at the top position.
                    if ({1'b0, goal_flap} == {1'b0, shown_flap} + 9'd1)
                    begin
                        drum_mode = sfpc_pkg::FSM_LAST;
                        deadline_ms = b.now_ms + {16'd0, flap_ms} - {16'd0, trim_ms};
                    end
                    else if (flap_fell(b.flap_sense))
                    begin
                        shown_flap = shown_flap + 1'b1;
                        trim_ms = '0;
                    end
                end
                sfpc_pkg::FSM_LAST:
                begin
                    if (deadline_hit(b.now_ms))
                        brake_on_last(b.now_ms);
                    else if (flap_fell(b.flap_sense))
                        brake_on_last(b.now_ms);
                end
                default:
                begin
                    if (deadline_hit(b.now_ms))
                        drum_mode = sfpc_pkg::FSM_STOPPED;
                end
            endcase
        end
        r.motor_drive = motor_on;
        r.position    = shown_flap;
        r.fsm_state   = drum_mode;
        r.done_res    = done;
    endtask

    // Sender idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_bus || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one input beat and record the result it should produce.
    task automatic send_beat(input sfpc_pkg::in_beat_t b);
        sfpc_pkg::out_beat_t r;
        int                  gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        drum_step(b, r);
        pending_reports.push_back(r);
        items_sent++;
        if (b.command == sfpc_pkg::CMD_SET)
            set_beats++;
    endtask

    task automatic tick(input logic [sfpc_pkg::TIME_BITS-1:0] now, input logic fs,
                        input logic hs);
        sfpc_pkg::in_beat_t b;
        b.command      = sfpc_pkg::CMD_TICK;
        b.target_value = sfpc_pkg::COUNT_BITS'($urandom_range(0, 255));
        b.now_ms       = now;
        b.flap_sense   = fs;
        b.home_sense   = hs;
        send_beat(b);
    endtask

    task automatic set_target(input logic [sfpc_pkg::COUNT_BITS-1:0] value);
        sfpc_pkg::in_beat_t b;
        b.command      = sfpc_pkg::CMD_SET;
        b.target_value = value;
        b.now_ms       = $urandom;
        b.flap_sense   = 1'($urandom_range(0, 1));
        b.home_sense   = 1'($urandom_range(0, 1));
        send_beat(b);
    endtask

    // Stop sending and wait until every result beat has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sfpc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [sfpc_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sfpc_pkg::REG_FLAP_COUNT:        flap_total = value[sfpc_pkg::COUNT_BITS-1:0];
            sfpc_pkg::REG_SPINUP_DELAY:      spinup_ms      = value;
            sfpc_pkg::REG_SHUTOFF_DELAY:     shutoff_ms     = value;
            sfpc_pkg::REG_FLAP_DELAY:        flap_ms        = value;
            sfpc_pkg::REG_SPINUP_CORRECTION: spinup_trim_ms = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Load all five registers; the block must be idle.
    task automatic apply_setup(input logic [sfpc_pkg::CFG_DATA_BITS-1:0] flaps,
                               input logic [15:0] spinup,
                               input logic [15:0] shutoff, input logic [15:0] flap_delay,
                               input logic [15:0] trim);
        write_reg(sfpc_pkg::REG_FLAP_COUNT, flaps);
        write_reg(sfpc_pkg::REG_SPINUP_DELAY, spinup);
        write_reg(sfpc_pkg::REG_SHUTOFF_DELAY, shutoff);
        write_reg(sfpc_pkg::REG_FLAP_DELAY, flap_delay);
        write_reg(sfpc_pkg::REG_SPINUP_CORRECTION, trim);
        setups_run++;
    endtask

    // Result side: random stalls; in calm stretches it is ready once any held stall ends.
    always @(posedge clk)
    begin
        int roll;
        roll = $urandom_range(0, 99);
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (calm_bus || roll < 65)
            out_ready <= 1'b1;
        else
        begin
            out_ready  <= 1'b0;
            ready_hold <= (roll < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    task automatic check_report(input sfpc_pkg::out_beat_t got);
        sfpc_pkg::out_beat_t want;
        if (pending_reports.size() == 0)
        begin
            report_errors++;
            if (report_errors <= REPORT_LIMIT)
                $display("ERROR: result beat %p arrived with nothing pending", got);
            return;
        end
        want = pending_reports.pop_front();
        checked_reports++;
        if (got.motor_drive !== want.motor_drive || got.position !== want.position ||
            got.fsm_state !== want.fsm_state || got.done_res !== want.done_res)
        begin
            report_errors++;
            if (report_errors <= REPORT_LIMIT)
                $display({"ERROR: beat %0d expected motor %b pos %0d state %0d done %b,",
                          " got motor %b pos %0d state %0d done %b"},
                         checked_reports, want.motor_drive, want.position, want.fsm_state,
                         want.done_res, got.motor_drive, got.position, got.fsm_state,
                         got.done_res);
        end
    endtask

    // Sample at the falling edge, where the handshake of the next rising edge is settled.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_report(out_data);
    end

    // Target extremes, a spin-up deadline across the time wrap, stepping and the last flap.
    task automatic test_target_and_wrap();
        tick(32'h0000_0000, 1'b0, 1'b0);
        set_target(8'd255);
        set_target(8'd0);
        set_target(8'd42);
        tick(32'hFFFF_FFC0, 1'b1, 1'b1);
        tick(32'hFFFF_FFF0, 1'b1, 1'b1);
        tick(32'h0000_0030, 1'b1, 1'b1);
        tick(32'h0000_0031, 1'b0, 1'b1);
        tick(32'h0000_0032, 1'b1, 1'b1);
        tick(32'h0000_0033, 1'b1, 1'b1);
        tick(32'h0000_0034, 1'b0, 1'b1);
        tick(32'h0000_0040, 1'b0, 1'b1);
        tick(32'h0000_00A0, 1'b0, 1'b1);
        tick(32'h0000_00A1, 1'b1, 1'b1);
    endtask

    // A lower target goes home first; spin-up here ends on a flap edge.
    task automatic test_homing();
        set_target(8'd1);
        tick(32'h0000_0100, 1'b1, 1'b1);
        tick(32'h0000_0101, 1'b1, 1'b1);
        tick(32'h0000_0102, 1'b0, 1'b1);
        tick(32'h0000_0103, 1'b0, 1'b0);
    endtask

    // Zero flap count keeps the raw target; a correction above the flap delay
    // puts the last-flap deadline in the past.
    task automatic test_corner_setup();
        settle();
        apply_setup(16'd0, 16'd0, 16'd0, 16'd10, 16'd500);
        set_target(8'd250);
        set_target(8'd1);
        tick(32'h0000_0200, 1'b1, 1'b1);
        tick(32'h0000_0201, 1'b1, 1'b1);
        tick(32'h0000_0202, 1'b1, 1'b1);
        tick(32'h0000_0203, 1'b1, 1'b1);
        tick(32'h0000_0204, 1'b1, 1'b1);
        tick(32'h0000_0205, 1'b1, 1'b1);
        tick(32'h0000_0206, 1'b0, 1'b0);
    endtask

    // One tick of the simulated drum: time moves on, the flap sensor toggles at random.
    task automatic drum_tick();
        if ($urandom_range(0, 49) == 0)
            drum_clock_ms = drum_clock_ms + $urandom;
        else
            drum_clock_ms = drum_clock_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 2) == 0)
            flap_level = !flap_level;
        tick(drum_clock_ms, flap_level, $urandom_range(0, 7) != 0);
    endtask

    // A move: set a target, then tick until the drum reports done or the cap is hit.
    task automatic run_move();
        int n;
        set_target(sfpc_pkg::COUNT_BITS'($urandom_range(0, 255)));
        for (n = 0; n < MOVE_TICK_CAP && items_sent < phase_end; n++)
        begin
            if (n > 0 && drum_mode == sfpc_pkg::FSM_STOPPED && goal_flap == shown_flap)
                break;
            if ($urandom_range(0, 39) == 0)
                set_target(sfpc_pkg::COUNT_BITS'($urandom_range(0, 255)));
            drum_tick();
        end
        drum_tick();
    endtask

    // Unstructured beats with every field random.
    task automatic send_noise();
        sfpc_pkg::in_beat_t b;
        int                 n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            b.command      = 1'($urandom_range(0, 1));
            b.target_value = sfpc_pkg::COUNT_BITS'($urandom_range(0, 255));
            b.now_ms       = $urandom;
            b.flap_sense   = 1'($urandom_range(0, 1));
            b.home_sense   = 1'($urandom_range(0, 1));
            send_beat(b);
        end
    endtask

    task automatic run_phase(input logic [15:0] flaps, input logic [15:0] spinup,
                             input logic [15:0] shutoff, input logic [15:0] flap_delay,
                             input logic [15:0] trim, input int step, input int count);
        settle();
        apply_setup(flaps, spinup, shutoff, flap_delay, trim);
        step_max      = step;
        drum_clock_ms = $urandom;
        phase_end     = items_sent + count;
        while (items_sent < phase_end)
        begin
            calm_bus = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8)
                run_move();
            else
                send_noise();
        end
        calm_bus = 1'b0;
    endtask

    // Random moves under a series of setups, the register extremes among them.
    task automatic test_random_moves();
        run_phase(16'd40, 16'd100, 16'd100, 16'd100, 16'd0, 40, 160);
        run_phase(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 5, 150);
        run_phase(16'd10, 16'd30, 16'd20, 16'd50, 16'd20, 15, 170);
        run_phase(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6000, 170);
        run_phase(16'd0, 16'd50, 16'd10, 16'd30, 16'd200, 20, 170);
        run_phase(16'd12, 16'd5, 16'd5, 16'hFFFF, 16'd1000, 30, 170);
        run_phase(16'($urandom_range(1, 64)), 16'($urandom_range(0, 200)),
                  16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                  16'($urandom_range(0, 300)), 25, 170);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_target_and_wrap();
        test_homing();
        test_corner_setup();
        test_random_moves();
        settle();
        $display("Sent %0d input beats (%0d set-target) across %0d register setups;",
                 items_sent, set_beats, setups_run);
        $display("checked %0d result beats, %0d mismatching.", checked_reports, report_errors);
        if (report_errors == 0 && pending_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Watchdog expired with %0d result beats outstanding.", pending_reports.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/sfpc_pkg.sv
design/sfpc_fifo.sv
design/sfpc_front.sv
design/sfpc_back.sv
design/split_flap_position_controller.sv
design/sfpc_checker.sv
tb/tb_split_flap_position_controller.sv
